[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[rtl/pil_pkg.sv]
// ----------------------------------------------------------------------------
// pil_pkg
// shared types and constants of the positional insert/delete list
// ----------------------------------------------------------------------------
package pil_pkg;

   localparam int DEPTH  = 128;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = 8;
   localparam int POS_W  = 8;
   localparam int WORD_W = 32;

   typedef enum logic [1:0] {
      ACT_APPEND = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_READ   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_DELETE = 2'd2,
      CELL_READ   = 2'd3
   } cell_op_type;

   typedef struct packed {
      action_type               action;
      logic [POS_W-1:0]         position;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic [CNT_W-1:0]         entry_count;
      logic signed [WORD_W-1:0] read_word;
   } rsp_type;

   typedef struct packed {
      cell_op_type       op;
      logic [IDX_W-1:0]  idx;
      logic [WORD_W-1:0] word;
   } cell_ctrl_type;

endpackage

[rtl/positional_insert_delete_list_top.sv]
// ----------------------------------------------------------------------------
// positional_insert_delete_list_top
// ordered list of signed words with append, insert, delete and read by
// position, built as a row of shifting slots
// ----------------------------------------------------------------------------
//  channel   ports                          direction  word
//  request   req_valid req_ready req_word   in         req_type
//  response  rsp_valid rsp_ready rsp_word   out        rsp_type
//
//  append, insert, delete and every refused request: response registered in
//  the cycle after acceptance; all slots shift together as the request is taken
//  successful read: response once the read bus has rippled from the addressed
//  slot one slot a cycle down to slot zero
//  a new request is taken once the previous response is gone or leaving
//  reset clears state, valid flag and count; slots hold nothing valid until written
// ----------------------------------------------------------------------------
module positional_insert_delete_list_top import pil_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_word
);

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   state_type         state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  wait_ff, wait_in;

   cell_ctrl_type     ctrl;
   logic [WORD_W-1:0] read_bus;
   logic              accept;
   logic              full;
   logic              empty;
   logic              pos_ok;
   logic [POS_W-1:0]  pos_m1;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign pos_ok    = (req_word.position != '0) && (req_word.position <= count_ff);
   assign pos_m1    = req_word.position - POS_W'(1);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      count_in     = count_ff;
      wait_in      = wait_ff;
      ctrl.op      = CELL_HOLD;
      ctrl.idx     = pos_m1[IDX_W-1:0];
      ctrl.word    = req_word.value;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_in.status    = STATUS_OK;
               rsp_in.read_word = '0;
               unique case (req_word.action)
                  ACT_APPEND: begin
                     if (full) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        ctrl.op  = CELL_INSERT;
                        ctrl.idx = count_ff[IDX_W-1:0];
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_INSERT: begin
                     if (full) begin
                        rsp_in.status = STATUS_FULL;
                     end else if (!pos_ok) begin
                        rsp_in.status = STATUS_RANGE;
                     end else begin
                        ctrl.op  = CELL_INSERT;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_DELETE: begin
                     if (empty) begin
                        rsp_in.status = STATUS_EMPTY;
                     end else if (!pos_ok) begin
                        rsp_in.status = STATUS_RANGE;
                     end else begin
                        ctrl.op  = CELL_DELETE;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  ACT_READ: begin
                     if (empty) begin
                        rsp_in.status = STATUS_EMPTY;
                     end else if (!pos_ok) begin
                        rsp_in.status = STATUS_RANGE;
                     end else begin
                        ctrl.op      = CELL_READ;
                        rsp_valid_in = 1'b0;
                        wait_in      = pos_m1[IDX_W-1:0];
                        state_in     = S_READ;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_in.entry_count = count_in;
            end
         end
         S_READ: begin
            if (wait_ff == '0) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = STATUS_OK;
               rsp_in.entry_count = count_ff;
               rsp_in.read_word   = read_bus;
               state_in           = S_IDLE;
            end else begin
               wait_in = wait_ff - IDX_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
      rsp_ff  <= rsp_in;
      wait_ff <= wait_in;
   end

   pil_chain u_chain (
      .clock    (clock),
      .ctrl     (ctrl),
      .read_bus (read_bus)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

[rtl/pil_cell.sv]
// ----------------------------------------------------------------------------
// pil_cell
// one list slot: holds an entry, takes a neighbour's word on a shift, and
// passes the read bus down towards slot zero
// ----------------------------------------------------------------------------
module pil_cell import pil_pkg::*; (
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   input  logic [IDX_W-1:0]  cell_index,
   input  logic [WORD_W-1:0] left_word,
   input  logic [WORD_W-1:0] right_word,
   input  logic [WORD_W-1:0] upper_bus,
   output logic [WORD_W-1:0] cell_word,
   output logic [WORD_W-1:0] bus_out
);

   logic [WORD_W-1:0] data_ff, data_in;
   logic [WORD_W-1:0] bus_ff, bus_in;

   always_comb begin
      data_in = data_ff;
      unique case (ctrl.op)
         CELL_HOLD: begin
         end
         CELL_INSERT: begin
            if (cell_index == ctrl.idx) begin
               data_in = ctrl.word;
            end else if (cell_index > ctrl.idx) begin
               data_in = left_word;
            end
         end
         CELL_DELETE: begin
            if (cell_index >= ctrl.idx) begin
               data_in = right_word;
            end
         end
         CELL_READ: begin
         end
         default: begin
         end
      endcase
   end

   // launch the addressed entry onto the bus, otherwise ripple down
   assign bus_in = (ctrl.op == CELL_READ && cell_index == ctrl.idx) ? data_ff : upper_bus;

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      bus_ff  <= bus_in;
   end

   assign cell_word = data_ff;
   assign bus_out   = bus_ff;

endmodule

[rtl/pil_chain.sv]
// ----------------------------------------------------------------------------
// pil_chain
// row of list slots wired to their neighbours
// ----------------------------------------------------------------------------
module pil_chain import pil_pkg::*; (
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   output logic [WORD_W-1:0] read_bus
);

   logic [WORD_W-1:0] slot_word [DEPTH];
   logic [WORD_W-1:0] bus_link  [DEPTH+1];

   assign bus_link[DEPTH] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_W-1:0] left_word;
      logic [WORD_W-1:0] right_word;

      if (i == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_left
         assign left_word = slot_word[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_right
         assign right_word = slot_word[i+1];
      end

      pil_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_index (IDX_W'(i)),
         .left_word  (left_word),
         .right_word (right_word),
         .upper_bus  (bus_link[i+1]),
         .cell_word  (slot_word[i]),
         .bus_out    (bus_link[i])
      );
   end

   assign read_bus = bus_link[0];

endmodule

[rtl/pil_checker.sv]
// ----------------------------------------------------------------------------
// pil_checker
// port-level checks of the positional list, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pil_checker import pil_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_word
);

   logic rsp_stalled;

   assign rsp_stalled = rsp_valid && !rsp_ready;

   // one request in flight: no new word while a response is stuck
   `ASSERT_IMPLY(a_no_take_when_stalled, clock, reset, rsp_stalled, !req_ready)

   // full only reported with a full list
   `ASSERT_IMPLY(a_full_count, clock, reset,
      rsp_valid && rsp_word.status == STATUS_FULL, rsp_word.entry_count == CNT_W'(DEPTH))

   // empty only reported with an empty list
   `ASSERT_IMPLY(a_empty_count, clock, reset,
      rsp_valid && rsp_word.status == STATUS_EMPTY, rsp_word.entry_count == '0)

   // a nonzero read word only comes with success
   `ASSERT_IMPLY(a_word_ok, clock, reset,
      rsp_valid && rsp_word.read_word != '0, rsp_word.status == STATUS_OK)

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stalled, rsp_valid && $stable(rsp_word))

endmodule

bind positional_insert_delete_list_top pil_checker u_pil_checker (.*);
